// ===== rtl/fdtsp_pkg.sv =====
// types and constants shared by the devicetree structure-block parser
package fdtsp_pkg;

    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_NAME  = 3'd1,
        PH_PLEN  = 3'd2,
        PH_POFF  = 3'd3,
        PH_PDATA = 3'd4,
        PH_PAD   = 3'd5
    } phase_t;

    localparam logic [2:0] EV_NODE_BEGIN = 3'd0;
    localparam logic [2:0] EV_NAME_BYTE  = 3'd1;
    localparam logic [2:0] EV_NODE_END   = 3'd2;
    localparam logic [2:0] EV_PROP_HDR   = 3'd3;
    localparam logic [2:0] EV_PROP_BYTE  = 3'd4;
    localparam logic [2:0] EV_NOP        = 3'd5;
    localparam logic [2:0] EV_END        = 3'd6;

    localparam logic [31:0] TAG_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TAG_END_NODE   = 32'd2;
    localparam logic [31:0] TAG_PROP       = 32'd3;
    localparam logic [31:0] TAG_NOP        = 32'd4;

    localparam int DEPTH_OUT_W = 7;
    localparam int OUT_DATA_W  = 80;

    typedef struct packed {
        logic [2:0]             event_kind;
        logic [7:0]             byte_value;
        logic [31:0]            prop_length;
        logic [31:0]            name_offset;
        logic [DEPTH_OUT_W-1:0] nest_depth;
        logic                   last_of_run;
    } event_t;

endpackage

// ===== rtl/fdtsp_in_stage.sv =====
// input register holding one structure-block byte
module fdtsp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // struct_byte
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ===== rtl/fdtsp_parser.sv =====
// token parser state and per-byte next-state and event logic
module fdtsp_parser #(
    parameter int MAX_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output logic              has_result,
    output fdtsp_pkg::event_t ev
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int XW = (DW > fdtsp_pkg::DEPTH_OUT_W) ? DW : fdtsp_pkg::DEPTH_OUT_W;
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    fdtsp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]        count_reg, count_next;
    logic [31:0]       word_reg, word_next;
    logic [31:0]       remain_reg, remain_next;
    logic [31:0]       held_reg, held_next;
    logic [1:0]        align_reg, align_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic              finished_reg, finished_next;

    logic        word_full;
    logic [31:0] remain_dec;
    logic [XW-1:0] depth_ext;

    assign word_full  = (count_reg == 2'd3);
    assign remain_dec = (remain_reg != 32'd0) ? remain_reg - 32'd1 : 32'd0;
    assign depth_ext  = XW'(depth_next);

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        word_next     = word_reg;
        remain_next   = remain_reg;
        held_next     = held_reg;
        align_next    = align_reg;
        depth_next    = depth_reg;
        finished_next = finished_reg;
        has_result    = 1'b0;
        ev            = '0;
        if (step && !finished_reg) begin
            align_next = align_reg + 2'd1;
            case (phase_reg)
                fdtsp_pkg::PH_NAME: begin
                    has_result    = 1'b1;
                    ev.event_kind = fdtsp_pkg::EV_NAME_BYTE;
                    if (in_byte == 8'd0) begin
                        ev.last_of_run = 1'b1;
                        phase_next = (align_next != 2'd0) ? fdtsp_pkg::PH_PAD
                                                          : fdtsp_pkg::PH_TAG;
                    end else begin
                        ev.byte_value = in_byte;
                    end
                end
                fdtsp_pkg::PH_PLEN: begin
                    word_next  = {word_reg[23:0], in_byte};
                    count_next = word_full ? 2'd0 : count_reg + 2'd1;
                    if (word_full) begin
                        held_next  = word_next;
                        phase_next = fdtsp_pkg::PH_POFF;
                    end
                end
                fdtsp_pkg::PH_POFF: begin
                    word_next  = {word_reg[23:0], in_byte};
                    count_next = word_full ? 2'd0 : count_reg + 2'd1;
                    if (word_full) begin
                        has_result     = 1'b1;
                        ev.event_kind  = fdtsp_pkg::EV_PROP_HDR;
                        ev.prop_length = held_reg;
                        ev.name_offset = word_next;
                        if (held_reg == 32'd0) begin
                            phase_next = fdtsp_pkg::PH_TAG;
                        end else begin
                            remain_next = held_reg;
                            phase_next  = fdtsp_pkg::PH_PDATA;
                        end
                    end
                end
                fdtsp_pkg::PH_PDATA: begin
                    has_result    = 1'b1;
                    ev.event_kind = fdtsp_pkg::EV_PROP_BYTE;
                    ev.byte_value = in_byte;
                    remain_next   = remain_dec;
                    if (remain_dec == 32'd0) begin
                        ev.last_of_run = 1'b1;
                        phase_next = (align_next != 2'd0) ? fdtsp_pkg::PH_PAD
                                                          : fdtsp_pkg::PH_TAG;
                    end
                end
                fdtsp_pkg::PH_PAD: begin
                    if (align_next == 2'd0) begin
                        phase_next = fdtsp_pkg::PH_TAG;
                    end
                end
                default: begin
                    phase_next = fdtsp_pkg::PH_TAG;
                    word_next  = {word_reg[23:0], in_byte};
                    count_next = word_full ? 2'd0 : count_reg + 2'd1;
                    if (word_full) begin
                        has_result = 1'b1;
                        case (word_next)
                            fdtsp_pkg::TAG_BEGIN_NODE: begin
                                if (depth_reg < DEPTH_MAX) begin
                                    depth_next = depth_reg + DW'(1);
                                end
                                phase_next    = fdtsp_pkg::PH_NAME;
                                ev.event_kind = fdtsp_pkg::EV_NODE_BEGIN;
                            end
                            fdtsp_pkg::TAG_END_NODE: begin
                                if (depth_reg != '0) begin
                                    depth_next = depth_reg - DW'(1);
                                end
                                ev.event_kind = fdtsp_pkg::EV_NODE_END;
                            end
                            fdtsp_pkg::TAG_PROP: begin
                                has_result = 1'b0;
                                phase_next = fdtsp_pkg::PH_PLEN;
                            end
                            fdtsp_pkg::TAG_NOP: begin
                                ev.event_kind = fdtsp_pkg::EV_NOP;
                            end
                            default: begin
                                finished_next = 1'b1;
                                ev.event_kind = fdtsp_pkg::EV_END;
                            end
                        endcase
                    end
                end
            endcase
            ev.nest_depth = depth_ext[fdtsp_pkg::DEPTH_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= fdtsp_pkg::PH_TAG;
            count_reg    <= 2'd0;
            word_reg     <= 32'd0;
            remain_reg   <= 32'd0;
            held_reg     <= 32'd0;
            align_reg    <= 2'd0;
            depth_reg    <= '0;
            finished_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            word_reg     <= word_next;
            remain_reg   <= remain_next;
            held_reg     <= held_next;
            align_reg    <= align_next;
            depth_reg    <= depth_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== rtl/fdtsp_out_stage.sv =====
// result register driving the event stream
module fdtsp_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              has_result,
    input  fdtsp_pkg::event_t                 ev,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fdtsp_pkg::OUT_DATA_W-1:0]  m_tdata,  // byte_value, prop_length, name_offset, nest_depth
    output logic [2:0]                        m_tuser,  // event_kind
    output logic                              m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    fdtsp_pkg::event_t ev_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = ev_reg.event_kind;
    assign m_tlast  = ev_reg.last_of_run;
    assign m_tdata  = {1'b0, ev_reg.nest_depth, ev_reg.name_offset,
                       ev_reg.prop_length, ev_reg.byte_value};

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = has_result;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (advance && has_result) begin
            ev_reg <= ev;
        end
    end

endmodule

// ===== rtl/devicetree_struct_token_parser_unit.sv =====
// top level of the devicetree structure-block token parser
// an accepted byte is held in the input register and its result beat in the result register
// throughput: one byte per cycle while the result side is not stalled, with combinational
// tag and run logic between the input register and the result register
// reset (aresetn low, synchronous) returns to expecting a tag at depth zero;
// after an end or unknown tag, beats are taken and dropped until reset
module devicetree_struct_token_parser_unit #(
    parameter int MAX_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // struct_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fdtsp_pkg::OUT_DATA_W-1:0]  m_tdata,  // byte_value, prop_length, name_offset, nest_depth
    output logic [2:0]                        m_tuser,  // event_kind
    output logic                              m_tlast
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              out_free;
    logic              advance;
    logic              has_result;
    fdtsp_pkg::event_t ev;

    assign advance = in_valid && out_free;

    fdtsp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    fdtsp_parser #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .in_byte    (in_byte),
        .has_result (has_result),
        .ev         (ev)
    );

    fdtsp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .has_result (has_result),
        .ev         (ev),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== sim/tb.sv =====
// testbench for the devicetree structure-block token parser: byte stream in, event beats checked
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEPTH     = 64;
    localparam int RANDOM_BYTES  = 1750;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [31:0] TAG_END = 32'd9;

    typedef struct {
        logic [7:0]        data;
        bit                typed;
        fdtsp_pkg::event_t ev;
    } stim_t;

    localparam fdtsp_pkg::event_t NONE = '0;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata  = 8'h00;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [fdtsp_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic [2:0]                        m_tuser;
    logic                              m_tlast;

    devicetree_struct_token_parser_unit #(
        .MAX_DEPTH(MAX_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // directed opening: depth floor, nop, node with name and padding, empty property
    stim_t directed_rows [28] = '{
        '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h02, 1'b1, fdtsp_pkg::event_t'{fdtsp_pkg::EV_NODE_END,
                                           8'h00, 32'h0, 32'h0, 7'd0, 1'b0}},
        '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h04, 1'b1, fdtsp_pkg::event_t'{fdtsp_pkg::EV_NOP,
                                           8'h00, 32'h0, 32'h0, 7'd0, 1'b0}},
        '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h01, 1'b1, fdtsp_pkg::event_t'{fdtsp_pkg::EV_NODE_BEGIN,
                                           8'h00, 32'h0, 32'h0, 7'd1, 1'b0}},
        '{8'hFF, 1'b1, fdtsp_pkg::event_t'{fdtsp_pkg::EV_NAME_BYTE,
                                           8'hFF, 32'h0, 32'h0, 7'd1, 1'b0}},
        '{8'h00, 1'b1, fdtsp_pkg::event_t'{fdtsp_pkg::EV_NAME_BYTE,
                                           8'h00, 32'h0, 32'h0, 7'd1, 1'b1}},
        '{8'hAA, 1'b0, NONE}, '{8'h55, 1'b0, NONE},
        '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h03, 1'b0, NONE},
        '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h00, 1'b0, NONE},
        '{8'hFF, 1'b0, NONE}, '{8'hFF, 1'b0, NONE}, '{8'hFF, 1'b0, NONE},
        '{8'hFF, 1'b1, fdtsp_pkg::event_t'{fdtsp_pkg::EV_PROP_HDR,
                                           8'h00, 32'h0, 32'hFFFF_FFFF, 7'd1, 1'b0}}
    };

    stim_t             struct_bytes [$];
    fdtsp_pkg::event_t pending_events [$];
    int                stream_pos;
    int                failures;
    int                bytes_accepted;
    int                events_seen;
    int                kind_seen [7];
    int                peak_depth;
    int                cycle_count;
    int                send_calm;
    int                recv_calm;
    int                stall_left;

    // parser state mirrored by the predictor
    fdtsp_pkg::phase_t phase;
    logic [1:0]        word_count;
    logic [31:0]       word_bits;
    logic [31:0]       data_left;
    logic [31:0]       held_len;
    logic [1:0]        align_pos;
    int                depth;
    bit                stopped;

    function automatic bit take_word(input logic [7:0] b);
        word_bits = {word_bits[23:0], b};
        if (word_count < 2'd3) begin
            word_count = word_count + 2'd1;
            return 1'b0;
        end
        word_count = 2'd0;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output fdtsp_pkg::event_t ev);
        bit hit;
        hit = 1'b0;
        ev  = '0;
        if (stopped)
            return 1'b0;
        align_pos = align_pos + 2'd1;
        case (phase)
            fdtsp_pkg::PH_NAME: begin
                hit = 1'b1;
                ev.event_kind = fdtsp_pkg::EV_NAME_BYTE;
                ev.byte_value = b;
                if (b == 8'h00) begin
                    ev.last_of_run = 1'b1;
                    phase = (align_pos != 2'd0) ? fdtsp_pkg::PH_PAD : fdtsp_pkg::PH_TAG;
                end
            end
            fdtsp_pkg::PH_PLEN: begin
                if (take_word(b)) begin
                    held_len = word_bits;
                    phase = fdtsp_pkg::PH_POFF;
                end
            end
            fdtsp_pkg::PH_POFF: begin
                if (take_word(b)) begin
                    hit = 1'b1;
                    ev.event_kind  = fdtsp_pkg::EV_PROP_HDR;
                    ev.prop_length = held_len;
                    ev.name_offset = word_bits;
                    data_left = held_len;
                    phase = (held_len == 32'd0) ? fdtsp_pkg::PH_TAG : fdtsp_pkg::PH_PDATA;
                end
            end
            fdtsp_pkg::PH_PDATA: begin
                if (data_left != 32'd0)
                    data_left = data_left - 32'd1;
                hit = 1'b1;
                ev.event_kind = fdtsp_pkg::EV_PROP_BYTE;
                ev.byte_value = b;
                if (data_left == 32'd0) begin
                    ev.last_of_run = 1'b1;
                    phase = (align_pos != 2'd0) ? fdtsp_pkg::PH_PAD : fdtsp_pkg::PH_TAG;
                end
            end
            fdtsp_pkg::PH_PAD: begin
                if (align_pos == 2'd0)
                    phase = fdtsp_pkg::PH_TAG;
            end
            default: begin
                phase = fdtsp_pkg::PH_TAG;
                if (take_word(b)) begin
                    hit = 1'b1;
                    case (word_bits)
                        fdtsp_pkg::TAG_BEGIN_NODE: begin
                            if (depth < MAX_DEPTH)
                                depth++;
                            phase = fdtsp_pkg::PH_NAME;
                            ev.event_kind = fdtsp_pkg::EV_NODE_BEGIN;
                        end
                        fdtsp_pkg::TAG_END_NODE: begin
                            if (depth > 0)
                                depth--;
                            ev.event_kind = fdtsp_pkg::EV_NODE_END;
                        end
                        fdtsp_pkg::TAG_PROP: begin
                            hit = 1'b0;
                            phase = fdtsp_pkg::PH_PLEN;
                        end
                        fdtsp_pkg::TAG_NOP: begin
                            ev.event_kind = fdtsp_pkg::EV_NOP;
                        end
                        default: begin
                            stopped = 1'b1;
                            ev.event_kind = fdtsp_pkg::EV_END;
                        end
                    endcase
                end
            end
        endcase
        ev.nest_depth = depth[fdtsp_pkg::DEPTH_OUT_W-1:0];
        return hit;
    endfunction

    function automatic int pick_hold(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(40, 150);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function void put(input logic [7:0] b);
        stim_t s;
        s.data  = b;
        s.typed = 1'b0;
        s.ev    = NONE;
        struct_bytes.push_back(s);
        stream_pos++;
    endfunction

    function void put_word(input logic [31:0] w);
        put(w[31:24]);
        put(w[23:16]);
        put(w[15:8]);
        put(w[7:0]);
    endfunction

    function void put_pad();
        while (stream_pos % 4 != 0)
            put(8'($urandom_range(0, 255)));
    endfunction

    function void put_node(input int name_len);
        put_word(fdtsp_pkg::TAG_BEGIN_NODE);
        repeat (name_len)
            put(8'($urandom_range(1, 255)));
        put(8'h00);
        put_pad();
    endfunction

    function void build_random_stream();
        int start;
        int r;
        int len;
        int open_nodes;
        bit dove;
        logic [31:0] w;
        start = stream_pos;
        open_nodes = 1;
        dove = 1'b0;
        while (stream_pos - start < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (!dove && stream_pos - start > 600) begin
                // push past the depth ceiling, then unwind below zero
                repeat (MAX_DEPTH + 3)
                    put_node(0);
                repeat (MAX_DEPTH + 5)
                    put_word(fdtsp_pkg::TAG_END_NODE);
                open_nodes = 0;
                dove = 1'b1;
            end else if (r < 28 && open_nodes < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(0, 8);
                put_node(len);
                open_nodes++;
            end else if (r < 50) begin
                put_word(fdtsp_pkg::TAG_END_NODE);
                if (open_nodes > 0)
                    open_nodes--;
            end else if (r < 88) begin
                r = $urandom_range(0, 99);
                len = (r < 25) ? 0 : (r < 95) ? $urandom_range(1, 12)
                                              : $urandom_range(13, 48);
                put_word(fdtsp_pkg::TAG_PROP);
                put_word(len);
                put_word($urandom());
                repeat (len)
                    put(8'($urandom_range(0, 255)));
                put_pad();
            end else begin
                put_word(fdtsp_pkg::TAG_NOP);
            end
        end
        // the stream closes with an end tag, an unknown tag, or a runaway property
        case ($urandom_range(0, 2))
            0: put_word(TAG_END);
            1: begin
                w = $urandom();
                while (w >= fdtsp_pkg::TAG_BEGIN_NODE && w <= fdtsp_pkg::TAG_NOP)
                    w = $urandom();
                put_word(w);
            end
            default: begin
                put_word(fdtsp_pkg::TAG_PROP);
                put_word($urandom() | 32'h8000_0000);
                put_word($urandom());
            end
        endcase
        repeat ($urandom_range(8, 20))
            put(8'($urandom_range(0, 255)));
    endfunction

    function void note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    function string show(input fdtsp_pkg::event_t e);
        return $sformatf("kind %0d byte %02h len %08h off %08h depth %0d last %0b",
                         e.event_kind, e.byte_value, e.prop_length, e.name_offset,
                         e.nest_depth, e.last_of_run);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, pending_events.size());
            $display("FAIL devicetree_struct_token_parser_unit");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            hold = pick_hold(recv_calm);
            if (hold > 0) begin
                stall_left = hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result beat checker
    always @(posedge aclk) begin
        fdtsp_pkg::event_t got;
        fdtsp_pkg::event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_kind  = m_tuser;
            got.byte_value  = m_tdata[7:0];
            got.prop_length = m_tdata[39:8];
            got.name_offset = m_tdata[71:40];
            got.nest_depth  = m_tdata[78:72];
            got.last_of_run = m_tlast;
            events_seen++;
            if (got.event_kind < 3'd7)
                kind_seen[got.event_kind]++;
            if (got.nest_depth > peak_depth)
                peak_depth = got.nest_depth;
            if (pending_events.size() == 0) begin
                note_failure({"unexpected beat: ", show(got)});
            end else begin
                want = pending_events.pop_front();
                if (got !== want)
                    note_failure({"expected ", show(want), " got ", show(got)});
            end
        end
    end

    initial begin
        stim_t             it;
        fdtsp_pkg::event_t ev;
        bit                hit;
        int                gap;

        phase      = fdtsp_pkg::PH_TAG;
        word_count = 2'd0;
        word_bits  = 32'd0;
        data_left  = 32'd0;
        held_len   = 32'd0;
        align_pos  = 2'd0;
        depth      = 0;
        stopped    = 1'b0;

        foreach (directed_rows[i]) begin
            struct_bytes.push_back(directed_rows[i]);
            stream_pos++;
        end
        build_random_stream();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (struct_bytes.size() != 0) begin
            it  = struct_bytes.pop_front();
            gap = pick_hold(send_calm);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.data;
            do @(posedge aclk); while (!s_tready);
            bytes_accepted++;
            hit = parse_byte(it.data, ev);
            if (it.typed)
                pending_events.push_back(it.ev);
            else if (hit)
                pending_events.push_back(ev);
        end
        s_tvalid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_events.size() != 0)
            note_failure($sformatf("%0d events never arrived", pending_events.size()));

        $display("%0d bytes fed, %0d events: %0d node begins, %0d name bytes, %0d node ends",
                 bytes_accepted, events_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("%0d property headers, %0d data bytes, %0d nops, %0d ends, peak depth %0d",
                 kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6], peak_depth);
        if (failures == 0)
            $display("PASS devicetree_struct_token_parser_unit");
        else
            $display("FAIL devicetree_struct_token_parser_unit");
        $finish;
    end

endmodule
